FILE: rtl/tdh_pkg.sv
// Shared constants, codes and types of the timer deadline heap.
`default_nettype none
package tdh_pkg;
  localparam int CAPACITY_DEF  = 32;
  localparam int TIME_BITS_DEF = 48;
  localparam int TAG_BITS_DEF  = 8;
  localparam int STAMP_BITS    = 16;
  localparam int MAX_RESULTS   = 32;
  localparam int COUNT_OUT_W   = 6;
  localparam int RES_W         = 6;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_TICK   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_DUE       = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_NOTHING   = 3'd5
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/tdh_if.sv
// Valid/ready channel interfaces for timer requests and timer results.
`default_nettype none
interface tdh_in_if #(
  parameter int TIME_BITS = tdh_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = tdh_pkg::TAG_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [TAG_BITS-1:0]  timer_tag;
  logic [TIME_BITS-1:0] due_time;
  logic [TIME_BITS-1:0] now_time;
  modport source (output valid, opcode, timer_tag, due_time, now_time, input ready);
  modport sink (input valid, opcode, timer_tag, due_time, now_time, output ready);
endinterface

interface tdh_out_if #(
  parameter int TIME_BITS = tdh_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = tdh_pkg::TAG_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [2:0]                         status;
  logic [TAG_BITS-1:0]                out_tag;
  logic [TIME_BITS-1:0]               earliest_pending;
  logic [tdh_pkg::COUNT_OUT_W-1:0]    pending_count;
  logic                               last;
  modport source (output valid, status, out_tag, earliest_pending, pending_count, last,
                  input ready);
  modport sink (input valid, status, out_tag, earliest_pending, pending_count, last,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/timer_deadline_heap.sv
// Top level of the timer deadline heap: sequencer around a binary min-heap store.
//
// Requests arrive on in_ch (opcode, timer_tag, due_time, now_time) and results
// leave on out_ch (status, out_tag, earliest_pending, pending_count, last).
// The block takes one request at a time; in_ch.ready is high only while idle.
// Every heap step goes through the entry store, whose read data is registered,
// so each compare step of a sift has an address state and a compare state.
// Enqueue: a sift up from the new last slot if there is room, then one result.
// Tick: a single result of status nothing when nothing is due, else a pop and a
// sift down per released timer; the last result of the tick carries last = 1.
// Cancel: a compaction scan over the queued entries, then a rebuild of the
// heap from the middle down, one sift per inner node.
// Results sit in an output register; while the receiver stalls, the sequencer
// holds at the point of the next transfer and resumes when the register frees.
// A synchronous reset empties the heap and restarts the insertion stamp; the
// entry store itself is not cleared, as only entries below the count are read.
`default_nettype none
module timer_deadline_heap #(
  parameter int CAPACITY  = tdh_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = tdh_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = tdh_pkg::TAG_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  tdh_in_if.sink   in_ch,
  tdh_out_if.source out_ch
);
  localparam int SB = tdh_pkg::STAMP_BITS;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam int EW = TIME_BITS + TAG_BITS + SB;
  localparam int RW = tdh_pkg::RES_W;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_UP      = 12'b000000000010,
    S_UP_W    = 12'b000000000100,
    S_DN      = 12'b000000001000,
    S_DN_W    = 12'b000000010000,
    S_CS      = 12'b000000100000,
    S_CS_W    = 12'b000001000000,
    S_HP      = 12'b000010000000,
    S_HP_W    = 12'b000100000000,
    S_POP_W   = 12'b001000000000,
    S_TOP_RD  = 12'b010000000000,
    S_TOP_CHK = 12'b100000000000
  } state_t;

  function automatic logic [TIME_BITS-1:0] e_dl(input logic [EW-1:0] e);
    return e[EW-1 -: TIME_BITS];
  endfunction

  function automatic logic [TAG_BITS-1:0] e_tag(input logic [EW-1:0] e);
    return e[SB +: TAG_BITS];
  endfunction

  function automatic logic key_less(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [SB-1:0] d;
    d = a[SB-1:0] - b[SB-1:0];
    if (e_dl(a) != e_dl(b)) begin
      return e_dl(a) < e_dl(b);
    end
    return d[SB-1];
  endfunction

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SB-1:0] seq, seq_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] hp_idx, hp_idx_next;
  logic [CW-1:0] keep, keep_next;
  logic [CW-1:0] scan, scan_next;
  logic [RW-1:0] nres, nres_next;
  logic found, found_next;
  logic op_tick, op_tick_next;
  logic pend, pend_next;
  tdh_pkg::status_t pend_status, pend_status_next;
  logic [TAG_BITS-1:0] pend_tag, pend_tag_next;
  logic [EW-1:0] cur, cur_next;
  logic [TAG_BITS-1:0] tag_r, tag_r_next;
  logic [TIME_BITS-1:0] now_r, now_r_next;

  logic out_valid, out_valid_next;
  tdh_pkg::status_t o_status, o_status_next;
  logic [TAG_BITS-1:0] o_tag, o_tag_next;
  logic [TIME_BITS-1:0] o_early, o_early_next;
  logic [tdh_pkg::COUNT_OUT_W-1:0] o_count, o_count_next;
  logic o_last, o_last_next;

  logic we;
  logic [IW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, rda, rdb;

  tdh_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rda), .rdata_b(rdb)
  );

  logic in_fire, out_free, top_ok, due, m_right;
  logic [XW-1:0] lidx, ridx;
  logic [IW-1:0] pidx, m_idx;
  logic [EW-1:0] m_e;
  logic [CW-1:0] count_dec;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign lidx = (XW'(idx) << 1) + XW'(1);
  assign ridx = lidx + XW'(1);
  assign pidx = (idx - IW'(1)) >> 1;
  assign m_right = (ridx < XW'(count)) && key_less(rdb, rda);
  assign m_e = m_right ? rdb : rda;
  assign m_idx = m_right ? ridx[IW-1:0] : lidx[IW-1:0];
  assign top_ok = (count != '0);
  assign due = op_tick && (nres < RW'(tdh_pkg::MAX_RESULTS)) && top_ok &&
               (e_dl(rda) <= now_r);
  assign count_dec = count - CW'(1);

  assign out_ch.valid = out_valid;
  assign out_ch.status = o_status;
  assign out_ch.out_tag = o_tag;
  assign out_ch.earliest_pending = o_early;
  assign out_ch.pending_count = o_count;
  assign out_ch.last = o_last;

  always_comb begin
    state_next = state;
    count_next = count;
    seq_next = seq;
    idx_next = idx;
    hp_idx_next = hp_idx;
    keep_next = keep;
    scan_next = scan;
    nres_next = nres;
    found_next = found;
    op_tick_next = op_tick;
    pend_next = pend;
    pend_status_next = pend_status;
    pend_tag_next = pend_tag;
    cur_next = cur;
    tag_r_next = tag_r;
    now_r_next = now_r;
    out_valid_next = out_valid && !out_ch.ready;
    o_status_next = o_status;
    o_tag_next = o_tag;
    o_early_next = o_early;
    o_count_next = o_count;
    o_last_next = o_last;
    we = 1'b0;
    waddr = idx;
    wdata = cur;
    raddr_a = '0;
    raddr_b = '0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (tdh_pkg::opcode_t'(in_ch.opcode))
            tdh_pkg::OP_ENQ: begin
              op_tick_next = 1'b0;
              pend_next = 1'b1;
              pend_tag_next = in_ch.timer_tag;
              if (count >= CW'(CAPACITY)) begin
                pend_status_next = tdh_pkg::ST_REJECTED;
                state_next = S_TOP_RD;
              end else begin
                pend_status_next = tdh_pkg::ST_ENQUEUED;
                cur_next = {in_ch.due_time, in_ch.timer_tag, seq};
                seq_next = seq + SB'(1);
                idx_next = count[IW-1:0];
                count_next = count + CW'(1);
                state_next = S_UP;
              end
            end
            tdh_pkg::OP_TICK: begin
              op_tick_next = 1'b1;
              now_r_next = in_ch.now_time;
              nres_next = '0;
              pend_next = 1'b0;
              state_next = S_TOP_RD;
            end
            tdh_pkg::OP_CANCEL: begin
              op_tick_next = 1'b0;
              tag_r_next = in_ch.timer_tag;
              scan_next = '0;
              keep_next = '0;
              found_next = 1'b0;
              state_next = S_CS;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_UP: begin
        if (idx == '0) begin
          we = 1'b1;
          state_next = S_TOP_RD;
        end else begin
          raddr_a = pidx;
          state_next = S_UP_W;
        end
      end
      S_UP_W: begin
        we = 1'b1;
        if (key_less(cur, rda)) begin
          wdata = rda;
          idx_next = pidx;
          state_next = S_UP;
        end else begin
          state_next = S_TOP_RD;
        end
      end
      S_DN: begin
        raddr_a = lidx[IW-1:0];
        raddr_b = ridx[IW-1:0];
        if (lidx >= XW'(count)) begin
          we = 1'b1;
          if (op_tick || hp_idx == '0) begin
            state_next = S_TOP_RD;
          end else begin
            hp_idx_next = hp_idx - IW'(1);
            state_next = S_HP;
          end
        end else begin
          state_next = S_DN_W;
        end
      end
      S_DN_W: begin
        we = 1'b1;
        if (key_less(m_e, cur)) begin
          wdata = m_e;
          idx_next = m_idx;
          state_next = S_DN;
        end else if (op_tick || hp_idx == '0) begin
          state_next = S_TOP_RD;
        end else begin
          hp_idx_next = hp_idx - IW'(1);
          state_next = S_HP;
        end
      end
      S_CS: begin
        raddr_a = scan[IW-1:0];
        if (scan < count) begin
          state_next = S_CS_W;
        end else begin
          pend_next = 1'b1;
          pend_tag_next = tag_r;
          if (found) begin
            count_next = keep;
            hp_idx_next = IW'(keep >> 1);
            pend_status_next = tdh_pkg::ST_CANCELLED;
            state_next = S_HP;
          end else begin
            pend_status_next = tdh_pkg::ST_NOTFOUND;
            state_next = S_TOP_RD;
          end
        end
      end
      S_CS_W: begin
        if (e_tag(rda) == tag_r) begin
          found_next = 1'b1;
        end else begin
          we = 1'b1;
          waddr = keep[IW-1:0];
          wdata = rda;
          keep_next = keep + CW'(1);
        end
        scan_next = scan + CW'(1);
        state_next = S_CS;
      end
      S_HP: begin
        raddr_a = hp_idx;
        state_next = S_HP_W;
      end
      S_HP_W: begin
        cur_next = rda;
        idx_next = hp_idx;
        state_next = S_DN;
      end
      S_POP_W: begin
        cur_next = rda;
        idx_next = '0;
        state_next = S_DN;
      end
      S_TOP_RD: begin
        raddr_a = '0;
        state_next = S_TOP_CHK;
      end
      S_TOP_CHK: begin
        // A pop reads the slot that the last entry leaves; while the state holds,
        // the top entry stays on the read port.
        raddr_a = (due && (!pend || out_free)) ? count_dec[IW-1:0] : '0;
        if (pend) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            o_status_next = pend_status;
            o_tag_next = pend_tag;
            o_early_next = top_ok ? e_dl(rda) : '1;
            o_count_next = tdh_pkg::COUNT_OUT_W'(count);
            o_last_next = !due;
            pend_next = 1'b0;
            state_next = S_IDLE;
          end
        end else if (!due && out_free) begin
          out_valid_next = 1'b1;
          o_status_next = tdh_pkg::ST_NOTHING;
          o_tag_next = '0;
          o_early_next = top_ok ? e_dl(rda) : '1;
          o_count_next = tdh_pkg::COUNT_OUT_W'(count);
          o_last_next = 1'b1;
          state_next = S_IDLE;
        end
        if (due && (!pend || out_free)) begin
          pend_next = 1'b1;
          pend_status_next = tdh_pkg::ST_DUE;
          pend_tag_next = e_tag(rda);
          count_next = count_dec;
          nres_next = nres + RW'(1);
          state_next = (count_dec != '0) ? S_POP_W : S_TOP_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      seq <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      seq <= seq_next;
      pend <= pend_next;
      out_valid <= out_valid_next;
    end
    idx <= idx_next;
    hp_idx <= hp_idx_next;
    keep <= keep_next;
    scan <= scan_next;
    nres <= nres_next;
    found <= found_next;
    op_tick <= op_tick_next;
    pend_status <= pend_status_next;
    pend_tag <= pend_tag_next;
    cur <= cur_next;
    tag_r <= tag_r_next;
    now_r <= now_r_next;
    o_status <= o_status_next;
    o_tag <= o_tag_next;
    o_early <= o_early_next;
    o_count <= o_count_next;
    o_last <= o_last_next;
  end
endmodule
`default_nettype wire

FILE: rtl/tdh_ram.sv
// Heap entry store: one write port and two registered read ports.
`default_nettype none
module tdh_ram #(
  parameter int DEPTH = tdh_pkg::CAPACITY_DEF,
  parameter int WIDTH = tdh_pkg::TIME_BITS_DEF + tdh_pkg::TAG_BITS_DEF + tdh_pkg::STAMP_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]              rdata_a,
  output logic [WIDTH-1:0]              rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

FILE: rtl/tdh_chk.sv
// Port-level assertions of the timer deadline heap and their bind.
`default_nettype none
module tdh_chk #(
  parameter int CAPACITY = tdh_pkg::CAPACITY_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] status,
  input wire logic       last,
  input wire logic [tdh_pkg::COUNT_OUT_W-1:0] pending_count
);
  // A held result must stay on the channel until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped or changed while stalled");

  // Only a due timer can be followed by more results of the same request.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != tdh_pkg::ST_DUE |-> last)
    else $error("single-result status without last");

  // No new request is taken while a non-final tick result is pending.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("request accepted in the middle of a tick");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && CAPACITY < 64 |-> 32'(pending_count) <= CAPACITY)
    else $error("pending count above capacity");
endmodule

bind timer_deadline_heap tdh_chk #(.CAPACITY(CAPACITY)) u_tdh_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .last(out_ch.last),
  .pending_count(out_ch.pending_count)
);
`default_nettype wire

FILE: verif/timer_result_checker.sv
// Checker for the timer deadline heap: heap model, result comparison and failure count.
`timescale 1ns / 100ps
`default_nettype none
module timer_result_checker (
  input  wire logic clk,
  input  wire logic rst,
  tdh_in_if         in_ch,
  tdh_out_if        out_ch,
  output int        fail_count,
  output int        awaited_count
);
  localparam int CAP = tdh_pkg::CAPACITY_DEF;
  localparam int TW  = tdh_pkg::TIME_BITS_DEF;
  localparam int GW  = tdh_pkg::TAG_BITS_DEF;
  localparam int SW  = tdh_pkg::STAMP_BITS;
  localparam int NW  = tdh_pkg::COUNT_OUT_W;
  localparam logic [TW-1:0] NO_DEADLINE = '1;

  typedef struct packed {
    tdh_pkg::status_t status;
    logic [GW-1:0]    tag;
    logic [TW-1:0]    earliest;
    logic [NW-1:0]    count;
    logic             last;
  } timer_result_t;

  logic [TW-1:0]  slot_due   [CAP];
  logic [GW-1:0]  slot_tag   [CAP];
  logic [SW-1:0]  slot_stamp [CAP];
  int unsigned    slot_used;
  logic [SW-1:0]  next_stamp;
  timer_result_t  timer_results_due[$];

  // Equal deadlines are ordered by stamp, with the stamp difference read modulo 2^16.
  function automatic bit fires_sooner(int unsigned a, int unsigned b);
    logic [SW-1:0] diff;
    if (slot_due[a] != slot_due[b]) return slot_due[a] < slot_due[b];
    diff = slot_stamp[a] - slot_stamp[b];
    return diff[SW-1];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [TW-1:0] d;
    logic [GW-1:0] t;
    logic [SW-1:0] s;
    d = slot_due[a];   slot_due[a] = slot_due[b];     slot_due[b] = d;
    t = slot_tag[a];   slot_tag[a] = slot_tag[b];     slot_tag[b] = t;
    s = slot_stamp[a]; slot_stamp[a] = slot_stamp[b]; slot_stamp[b] = s;
  endfunction

  function automatic void sift_down(int unsigned start);
    int unsigned i, l, m;
    i = start;
    forever begin
      l = 2 * i + 1;
      if (l >= slot_used) break;
      m = l;
      if (l + 1 < slot_used && fires_sooner(l + 1, l)) m = l + 1;
      if (!fires_sooner(m, i)) break;
      swap_slots(i, m);
      i = m;
    end
  endfunction

  function automatic void post_result(tdh_pkg::status_t st, logic [GW-1:0] tag);
    timer_result_t r;
    r.status   = st;
    r.tag      = tag;
    r.earliest = (slot_used > 0) ? slot_due[0] : NO_DEADLINE;
    r.count    = slot_used[NW-1:0];
    r.last     = 1'b0;
    timer_results_due.push_back(r);
  endfunction

  function automatic void predict_heap_op(tdh_pkg::opcode_t op, logic [GW-1:0] tag,
                                          logic [TW-1:0] due,
                                          logic [TW-1:0] now);
    int unsigned i, p, keep, released;
    bit hit;
    released = 0;
    hit = 1'b0;
    case (op)
      tdh_pkg::OP_ENQ: begin
        if (slot_used >= CAP) begin
          post_result(tdh_pkg::ST_REJECTED, tag);
        end else begin
          i = slot_used;
          slot_due[i] = due;
          slot_tag[i] = tag;
          slot_stamp[i] = next_stamp;
          next_stamp++;
          slot_used++;
          while (i > 0) begin
            p = (i - 1) / 2;
            if (!fires_sooner(i, p)) break;
            swap_slots(i, p);
            i = p;
          end
          post_result(tdh_pkg::ST_ENQUEUED, tag);
        end
      end
      tdh_pkg::OP_TICK: begin
        while (released < tdh_pkg::MAX_RESULTS && slot_used > 0 && slot_due[0] <= now) begin
          tag = slot_tag[0];
          slot_used--;
          if (slot_used > 0) begin
            swap_slots(0, slot_used);
            sift_down(0);
          end
          post_result(tdh_pkg::ST_DUE, tag);
          released++;
        end
        if (released == 0) post_result(tdh_pkg::ST_NOTHING, '0);
      end
      tdh_pkg::OP_CANCEL: begin
        keep = 0;
        for (i = 0; i < slot_used; i++) begin
          if (slot_tag[i] == tag) begin
            hit = 1'b1;
          end else begin
            slot_due[keep] = slot_due[i];
            slot_tag[keep] = slot_tag[i];
            slot_stamp[keep] = slot_stamp[i];
            keep++;
          end
        end
        if (hit) begin
          slot_used = keep;
          for (i = slot_used / 2 + 1; i > 0; i--) sift_down(i - 1);
          post_result(tdh_pkg::ST_CANCELLED, tag);
        end else begin
          post_result(tdh_pkg::ST_NOTFOUND, tag);
        end
      end
      default: return;
    endcase
    timer_results_due[$].last = 1'b1;
  endfunction

  assign awaited_count = timer_results_due.size();

  always @(posedge clk) begin
    timer_result_t want, got;
    if (rst) begin
      slot_used  <= 0;
      next_stamp <= '0;
      fail_count <= 0;
      timer_results_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_heap_op(tdh_pkg::opcode_t'(in_ch.opcode), in_ch.timer_tag, in_ch.due_time,
                        in_ch.now_time);
      if (out_ch.valid && out_ch.ready) begin
        got.status   = tdh_pkg::status_t'(out_ch.status);
        got.tag      = out_ch.out_tag;
        got.earliest = out_ch.earliest_pending;
        got.count    = out_ch.pending_count;
        got.last     = out_ch.last;
        if (timer_results_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d tag=%0d earliest=%0h count=%0d last=%0b",
                   $time, got.status, got.tag, got.earliest, got.count, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = timer_results_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status=%0d tag=%0d earliest=%0h count=%0d last=%0b",
                     $time, want.status, want.tag, want.earliest, want.count, want.last);
            $display("%0t:          actual   status=%0d tag=%0d earliest=%0h count=%0d last=%0b",
                     $time, got.status, got.tag, got.earliest, got.count, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: verif/timer_deadline_heap_tb.sv
// Testbench top for the timer deadline heap: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module timer_deadline_heap_tb;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TW = tdh_pkg::TIME_BITS_DEF;
  localparam int GW = tdh_pkg::TAG_BITS_DEF;
  localparam logic [TW-1:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 1'b0;
  int   fail_count, awaited_count;
  int   cycle_count = 0;
  int   stall_left = 0;
  logic [TW-1:0] clock_now = '0;

  tdh_in_if  in_ch ();
  tdh_out_if out_ch ();

  timer_deadline_heap dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  timer_result_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .awaited_count(awaited_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial out_ch.ready = 1'b0;

  // Receiver stalls in short bursts except during reset and the quiet tail.
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [TW-1:0] any_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TW-1:0];
  endfunction

  function automatic logic [GW-1:0] pick_tag(int unsigned hi);
    int unsigned v;
    v = $urandom_range(0, hi);
    return v[GW-1:0];
  endfunction

  // Drives one request from a falling edge and holds it until the transfer.
  task automatic send_request(tdh_pkg::opcode_t op, logic [GW-1:0] tag,
                              logic [TW-1:0] due,
                              logic [TW-1:0] now);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.timer_tag <= tag;
    in_ch.due_time  <= due;
    in_ch.now_time  <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random_request();
    int pick;
    logic [GW-1:0] tag;
    pick = $urandom_range(0, 99);
    tag = ($urandom_range(0, 3) == 0) ? pick_tag(255) : pick_tag(15);
    if (pick < 50) begin
      if ($urandom_range(0, 9) == 0)
        send_request(tdh_pkg::OP_ENQ, tag, any_time(), any_time());
      else
        send_request(tdh_pkg::OP_ENQ, tag, clock_now + TW'($urandom_range(0, 400)),
                     any_time());
    end else if (pick < 78) begin
      clock_now += TW'($urandom_range(0, 200));
      if ($urandom_range(0, 14) == 0)
        send_request(tdh_pkg::OP_TICK, tag, any_time(), TIME_MAX);
      else
        send_request(tdh_pkg::OP_TICK, tag, any_time(), clock_now);
    end else if (pick < 96) begin
      send_request(tdh_pkg::OP_CANCEL, tag, any_time(), any_time());
    end else begin
      send_request(tdh_pkg::OP_NONE, tag, any_time(), any_time());
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = tdh_pkg::OP_NONE;
    in_ch.timer_tag = '0;
    in_ch.due_time  = '0;
    in_ch.now_time  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, tie order, duplicate tags, unused opcode, empty heap.
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, TIME_MAX);
    send_request(tdh_pkg::OP_ENQ, 8'd0, '0, '0);
    send_request(tdh_pkg::OP_ENQ, 8'd255, TIME_MAX, '0);
    send_request(tdh_pkg::OP_ENQ, 8'd7, 48'd100, '0);
    send_request(tdh_pkg::OP_ENQ, 8'd9, 48'd100, '0);
    send_request(tdh_pkg::OP_ENQ, 8'd7, 48'd100, '0);
    send_request(tdh_pkg::OP_ENQ, 8'd11, 48'd100, '0);
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, '0);
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, 48'd50);
    send_request(tdh_pkg::OP_NONE, 8'd255, TIME_MAX, TIME_MAX);
    send_request(tdh_pkg::OP_CANCEL, 8'd7, '0, '0);
    send_request(tdh_pkg::OP_CANCEL, 8'd7, '0, '0);
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, 48'd100);
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, TIME_MAX - 1);
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, TIME_MAX);
    send_request(tdh_pkg::OP_CANCEL, 8'd255, '0, '0);

    // Fill past capacity, then release a full burst in a single tick.
    repeat (34) send_request(tdh_pkg::OP_ENQ, pick_tag(15), TW'($urandom_range(0, 60)), '0);
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, TIME_MAX);
    send_request(tdh_pkg::OP_TICK, 8'd0, '0, TIME_MAX);

    repeat (40) send_random_request();
    quiet = 1'b1;
    repeat (30) send_random_request();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
